### rtl/core/euler_to_quaternion_top_defines.svh
// Assertion macros for the quaternion block
`ifndef EULER_TO_QUATERNION_TOP_DEFINES_SVH
`define EULER_TO_QUATERNION_TOP_DEFINES_SVH
// assert that a implies b in the next cycle
`define E2Q_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("e2q check failed");
// assert that a implies b in the same cycle
`define E2Q_ASSERT_NOW(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("e2q check failed");
`endif

### rtl/core/e2q_pkg.sv
`timescale 1ns / 1ps
package e2q_pkg;
  localparam int CordicSteps = 16;
  localparam int AtanLen     = 30;
  localparam int Latency     = CordicSteps + 5;

  localparam logic signed [31:0] PiQ28     = 32'sd843314857;
  localparam logic signed [31:0] HalfPiQ28 = 32'sd421657428;
  localparam logic signed [31:0] GainQ30   = 32'sd652032874;
  localparam logic signed [17:0] OneQ16    = 18'sd65536;
  localparam logic signed [17:0] OneQ14    = 18'sd16384;

  typedef struct packed {
    logic signed [15:0] angle_x;
    logic signed [15:0] angle_y;
    logic signed [15:0] angle_z;
  } e2q_in_t;

  typedef struct packed {
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
  } e2q_out_t;

  function automatic logic signed [31:0] atan_q28(input int i);
    case (i)
      0: return 32'sd210828714;  1: return 32'sd124459457;
      2: return 32'sd65760959;   3: return 32'sd33381290;
      4: return 32'sd16755422;   5: return 32'sd8385879;
      6: return 32'sd4193963;    7: return 32'sd2097109;
      8: return 32'sd1048571;    9: return 32'sd524287;
      default: return (i < AtanLen - 1) ? (32'sd1 <<< (28 - i)) : 32'sd0;
    endcase
  endfunction
endpackage

### rtl/core/e2q_cordic_lane.sv
`timescale 1ns / 1ps
module e2q_cordic_lane
  import e2q_pkg::*;
(
  input  logic               clk,
  input  logic signed [15:0] angle,
  output logic signed [17:0] cos_q16,
  output logic signed [17:0] sin_q16
);
  // stage registers, index 0 is the folded start
  logic signed [32:0] xs [0:CordicSteps];
  logic signed [32:0] ys [0:CordicSteps];
  logic signed [31:0] zs [0:CordicSteps];
  logic               ng [0:CordicSteps];
  logic signed [31:0] z0;

  assign z0 = 32'(angle) <<< 15;

  // fold the half angle into [-pi/2, pi/2]
  always_ff @(posedge clk) begin
    xs[0] <= 33'(GainQ30);
    ys[0] <= '0;
    if (z0 > HalfPiQ28) begin
      zs[0] <= z0 - PiQ28;
      ng[0] <= 1'b1;
    end else if (z0 < -HalfPiQ28) begin
      zs[0] <= z0 + PiQ28;
      ng[0] <= 1'b1;
    end else begin
      zs[0] <= z0;
      ng[0] <= 1'b0;
    end
  end

  // advance one micro-rotation per stage
  for (genvar i = 0; i < CordicSteps; i++) begin : g_step
    always_ff @(posedge clk) begin
      ng[i+1] <= ng[i];
      if (zs[i] >= 0) begin
        xs[i+1] <= xs[i] - (ys[i] >>> i);
        ys[i+1] <= ys[i] + (xs[i] >>> i);
        zs[i+1] <= zs[i] - atan_q28(i);
      end else begin
        xs[i+1] <= xs[i] + (ys[i] >>> i);
        ys[i+1] <= ys[i] - (xs[i] >>> i);
        zs[i+1] <= zs[i] + atan_q28(i);
      end
    end
  end

  // negate, round to Q.16 and clamp
  logic signed [33:0] xf, yf, xr, yr;
  always_comb begin
    xf = ng[CordicSteps] ? -34'(xs[CordicSteps]) : 34'(xs[CordicSteps]);
    yf = ng[CordicSteps] ? -34'(ys[CordicSteps]) : 34'(ys[CordicSteps]);
    xr = (xf + 34'sd8192) >>> 14;
    yr = (yf + 34'sd8192) >>> 14;
  end

  always_ff @(posedge clk) begin
    cos_q16 <= (xr > 34'(OneQ16)) ? OneQ16 : (xr < -34'(OneQ16)) ? -OneQ16 : 18'(xr);
    sin_q16 <= (yr > 34'(OneQ16)) ? OneQ16 : (yr < -34'(OneQ16)) ? -OneQ16 : 18'(yr);
  end
endmodule

### rtl/core/e2q_merge.sv
`timescale 1ns / 1ps
module e2q_merge
  import e2q_pkg::*;
(
  input  logic               clk,
  input  logic signed [17:0] cx,
  input  logic signed [17:0] sx,
  input  logic signed [17:0] cy,
  input  logic signed [17:0] sy,
  input  logic signed [17:0] cz,
  input  logic signed [17:0] sz,
  output e2q_out_t           quat
);
  // first products, Q.32
  logic signed [34:0] czcy, czsy, szcy, szsy;
  logic signed [17:0] cx1, sx1;
  always_ff @(posedge clk) begin
    czcy <= 35'(cz * cy);
    czsy <= 35'(cz * sy);
    szcy <= 35'(sz * cy);
    szsy <= 35'(sz * sy);
    cx1  <= cx;
    sx1  <= sx;
  end

  // triple products, Q.48; magnitude at most 2^48
  logic signed [50:0] p_x0, p_x1, p_y0, p_y1, p_z0, p_z1, p_w0, p_w1;
  always_ff @(posedge clk) begin
    p_x0 <= 51'(sx1 * czcy);
    p_x1 <= 51'(cx1 * szsy);
    p_y0 <= 51'(cx1 * czsy);
    p_y1 <= 51'(sx1 * szcy);
    p_z0 <= 51'(cx1 * szcy);
    p_z1 <= 51'(sx1 * czsy);
    p_w0 <= 51'(cx1 * czcy);
    p_w1 <= 51'(sx1 * szsy);
  end

  function automatic logic signed [15:0] fin(input logic signed [50:0] v);
    logic signed [50:0] r;
    r = (v + (51'sd1 <<< 33)) >>> 34;
    if (r > 51'(OneQ14)) return 16'(OneQ14);
    if (r < -51'(OneQ14)) return -16'(OneQ14);
    return 16'(r);
  endfunction

  // sum, round and saturate
  always_ff @(posedge clk) begin
    quat.quat_x <= fin(p_x0 + p_x1);
    quat.quat_y <= fin(p_y0 - p_y1);
    quat.quat_z <= fin(p_z0 - p_z1);
    quat.quat_w <= fin(p_w0 + p_w1);
  end
endmodule

### rtl/core/euler_to_quaternion_top.sv
`timescale 1ns / 1ps
// Channel | Ports              | Handshake
// in      | start, busy, in_beat| accepted when start & !busy
// out     | done, out_beat     | one-cycle strobe, no back-pressure
// Fully pipelined: one beat per cycle; each beat passes through the stages
// fold, CordicSteps CORDIC stages, round and three merge stages.
// busy is held low: the pipeline never stalls.
// Synchronous reset clears only the valid line; payload holds no reset.
module euler_to_quaternion_top
  import e2q_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  e2q_in_t  in_beat,
  output logic     done,
  output e2q_out_t out_beat
);
  logic signed [17:0] cx, sx, cy, sy, cz, sz;
  logic [Latency-1:0] vld;

  assign busy = 1'b0;

  e2q_cordic_lane u_lx (.clk, .angle(in_beat.angle_x), .cos_q16(cx), .sin_q16(sx));
  e2q_cordic_lane u_ly (.clk, .angle(in_beat.angle_y), .cos_q16(cy), .sin_q16(sy));
  e2q_cordic_lane u_lz (.clk, .angle(in_beat.angle_z), .cos_q16(cz), .sin_q16(sz));

  e2q_merge u_merge (.clk, .cx, .sx, .cy, .sy, .cz, .sz, .quat(out_beat));

  // advance the valid line alongside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[Latency-2:0], start & ~busy};
    end
  end

  assign done = vld[Latency-1];
endmodule

### rtl/core/e2q_checker.sv
`timescale 1ns / 1ps
`include "euler_to_quaternion_top_defines.svh"
module e2q_checker
  import e2q_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     start,
  input logic     busy,
  input logic     done,
  input e2q_out_t out_beat
);
  // hold the w and x components within unit range on every result
  `E2Q_ASSERT_NOW(a_rng_w, clk, rst, done, (out_beat.quat_w <= 16'sd16384 && out_beat.quat_w >= -16'sd16384))
  `E2Q_ASSERT_NOW(a_rng_x, clk, rst, done, (out_beat.quat_x <= 16'sd16384 && out_beat.quat_x >= -16'sd16384))
  // drop no beat: an accepted start gives done after the fixed latency
  `E2Q_ASSERT_NOW(a_lat, clk, rst, ($past(start && !busy, Latency) && !$past(rst, Latency) && !$past(rst, Latency - 1)), done)
  // never refuse a beat
  `E2Q_ASSERT_NEXT(a_busy, clk, rst, 1'b1, !busy)
endmodule

bind euler_to_quaternion_top e2q_checker u_chk (
  .clk, .rst, .start, .busy, .done, .out_beat
);

### test/tb_euler_to_quaternion_top.sv
`timescale 1ns / 1ps
module tb_euler_to_quaternion_top;
  import e2q_pkg::*;

  // Fold and CORDIC constants, half angle Q.28, vector Q.30
  localparam longint PI_Q28   = 64'sd843314857;
  localparam longint HPI_Q28  = 64'sd421657428;
  localparam longint GAIN_Q30 = 64'sd652032874;
  localparam longint ONE_Q16  = 64'sd65536;
  localparam longint ONE_Q14  = 64'sd16384;
  localparam int     STEPS    = 16;
  localparam int     WATCHDOG = 5000;

  typedef enum int {PH_FREE, PH_SEND_IDLE, PH_RECV_IDLE, PH_BOTH} idle_phase_e;

  longint arctan_q28 [30] = '{
    210828714, 124459457, 65760959, 33381290, 16755422,
    8385879, 4193963, 2097109, 1048571, 524287,
    262144, 131072, 65536, 32768, 16384,
    8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16,
    8, 4, 2, 1, 0};

  function automatic longint clip(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Cosine and sine of half the Q3.12 angle, both Q.16
  function automatic void half_angle_trig(logic signed [15:0] ang,
                                          output longint c, output longint s);
    longint z, x, y, dx, dy;
    bit     flip;
    z = longint'(ang) * 32768;
    x = GAIN_Q30;
    y = 0;
    flip = 0;
    if (z > HPI_Q28) begin
      z -= PI_Q28;
      flip = 1;
    end else if (z < -HPI_Q28) begin
      z += PI_Q28;
      flip = 1;
    end
    for (int i = 0; i < STEPS && i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_q28[i];
      end else begin
        x += dx; y -= dy; z += arctan_q28[i];
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = clip((x + 8192) >>> 14, ONE_Q16);
    s = clip((y + 8192) >>> 14, ONE_Q16);
  endfunction

  function automatic logic signed [15:0] round_q14(longint q48);
    return 16'(clip((q48 + (64'sd1 <<< 33)) >>> 34, ONE_Q14));
  endfunction

  function automatic e2q_out_t angles_to_quat(e2q_in_t a);
    longint cx, sx, cy, sy, cz, sz;
    e2q_out_t q;
    half_angle_trig(a.angle_x, cx, sx);
    half_angle_trig(a.angle_y, cy, sy);
    half_angle_trig(a.angle_z, cz, sz);
    q.quat_x = round_q14(cz * sx * cy + sz * cx * sy);
    q.quat_y = round_q14(cz * cx * sy - sz * sx * cy);
    q.quat_z = round_q14(sz * cx * cy - cz * sx * sy);
    q.quat_w = round_q14(cz * cx * cy + sz * sx * sy);
    return q;
  endfunction

  class quat_scoreboard;
    e2q_out_t pending_quats[$];
    int       mismatches;
    int       matched;

    function void note_angles(e2q_in_t a);
      pending_quats.push_back(angles_to_quat(a));
    endfunction

    function void check_quat(e2q_out_t got);
      e2q_out_t want;
      if (pending_quats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", got);
        return;
      end
      want = pending_quats.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp x=%0d y=%0d z=%0d w=%0d got x=%0d y=%0d z=%0d w=%0d",
                   want.quat_x, want.quat_y, want.quat_z, want.quat_w,
                   got.quat_x, got.quat_y, got.quat_z, got.quat_w);
      end else begin
        matched++;
      end
    endfunction
  endclass

  logic     clk = 0;
  logic     rst = 1;
  logic     start = 0;
  logic     busy;
  e2q_in_t  in_beat = '0;
  logic     done;
  e2q_out_t out_beat;

  quat_scoreboard sb = new();
  int  idle_cycles = 0;
  int  sent = 0;

  euler_to_quaternion_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .in_beat(in_beat), .done(done), .out_beat(out_beat)
  );

  always #10 clk = ~clk;

  // Note accepted beats, check results, run the watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_angles(in_beat);
      if (done) sb.check_quat(out_beat);
      if ((start && !busy) || done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // Drive one beat, holding it until accepted
  task automatic send_angles(e2q_in_t a, int idle_pct);
    while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start   <= 1;
    in_beat <= a;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    start <= 0;
    while (sb.pending_quats.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_angle();
    case ($urandom_range(5, 0))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'($signed($urandom_range(400, 0)) - 200);
      3: return 16'($signed($urandom_range(12868, 0)) - 6434);
      default: return 16'($urandom());
    endcase
  endfunction

  // Watchdog: stop when nothing moves for too long
  initial begin
    wait (idle_cycles >= WATCHDOG);
    $display("watchdog expired");
    $display("Some tests failed");
    $finish;
  end

  initial begin
    logic signed [15:0] corners [12];
    e2q_in_t a;
    int pct;
    corners = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'sh0001, 16'shffff,
                16'sd6434, -16'sd6434, 16'sd6435, -16'sd6435,
                16'sd12868, -16'sd12868, 16'sd25736};
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: extremes, fold boundaries near +-pi, sign flips
    for (int i = 0; i < 12; i++) begin
      a.angle_x = corners[i];
      a.angle_y = corners[(i + 4) % 12];
      a.angle_z = corners[(i + 8) % 12];
      send_angles(a, 0);
    end
    for (int i = 0; i < 8; i++) begin
      a.angle_x = (i & 1) ? 16'sh8000 : 16'sh7fff;
      a.angle_y = (i & 2) ? 16'sh8000 : 16'sh7fff;
      a.angle_z = (i & 4) ? 16'sh8000 : 16'sh7fff;
      send_angles(a, 0);
    end
    // Pause until the pipe is empty
    drain();

    // Random beats across idling phases
    for (int p = 0; p < 4; p++) begin
      pct = (p == PH_SEND_IDLE || p == PH_BOTH) ? 62 : 0;
      for (int i = 0; i < 110; i++) begin
        a.angle_x = rand_angle();
        a.angle_y = rand_angle();
        a.angle_z = rand_angle();
        send_angles(a, pct);
      end
    end
    drain();
    repeat (Latency + 10) @(posedge clk);

    $display("Sent %0d angle triples, %0d quaternions matched, %0d mismatches",
             sent, sb.matched, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_quats.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
